/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

   // Command codes carried on the request channel.
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Data bits per byte transfer and the width of the bit counter.
   localparam int unsigned DATA_BITS   = 8;
   localparam int unsigned BIT_COUNT_W = $clog2(DATA_BITS + 1);

   // Bus phase counter: four phases per start or stop, three per data bit.
   localparam int unsigned PHASE_W = 2;

endpackage

/* hw/rtl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps

// Single-master I2C bit engine. While idle, a request transaction loads a
// command (start, stop, write byte, read byte with ACK or NAK answer); each
// later request transaction acts as a tick that moves the bus one phase and
// returns, in one response transaction, the SCL level, the SDA level and
// drive enable, busy and done flags, the last read byte and the last write
// acknowledge. A command that arrives while busy is treated as a tick. The
// block takes one request every clock cycle unless the response channel
// stalls; each request passes from the input register through the phase
// logic into the state and response registers, which drive the response
// channel. The phase update loops from the state registers through the phase
// logic back into them. Reset drives SCL and SDA high with SDA driven.
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_write_byte,
   input  logic       req_send_nak,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_nack
);

   localparam int unsigned BCW = i2cm_pkg::BIT_COUNT_W;
   localparam int unsigned PHW = i2cm_pkg::PHASE_W;
   localparam logic [BCW-1:0] LAST_BIT_COUNT = BCW'(i2cm_pkg::DATA_BITS);

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   // Input register.
   logic       in_valid_ff;
   logic [2:0] in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       in_nak_ff;
   logic       in_sample_ff;

   // Engine state; the line levels double as response registers.
   op_type           op_ff, op_in;
   logic [BCW-1:0]   bit_count_ff, bit_count_in;
   logic [PHW-1:0]   phase_ff, phase_in;
   logic [7:0]       shifter_ff, shifter_in;
   logic             nak_req_ff, nak_req_in;
   logic             ack_ff, ack_in;
   logic             scl_ff, scl_in;
   logic             sda_ff, sda_in;
   logic             sda_oe_ff, sda_oe_in;
   logic [7:0]       read_result_ff, read_result_in;
   logic             done_ff, done_in;
   logic             rsp_valid_ff;

   logic             advance;
   logic             data_bit;

   // The input register moves into the engine when the response slot frees up.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign data_bit  = (bit_count_ff < LAST_BIT_COUNT);

   // One bus phase per transaction while a command runs; while idle, a transaction may load a command.
   always_comb begin
      op_in          = op_ff;
      bit_count_in   = bit_count_ff;
      phase_in       = phase_ff + PHW'(1);
      shifter_in     = shifter_ff;
      nak_req_in     = nak_req_ff;
      ack_in         = ack_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      sda_oe_in      = sda_oe_ff;
      read_result_in = read_result_ff;
      done_in        = 1'b0;

      unique case (op_ff)
         OP_IDLE: begin
            phase_in = phase_ff;
            if (in_cmd_ff >= i2cm_pkg::CMD_START && in_cmd_ff <= i2cm_pkg::CMD_READ) begin
               op_in        = op_type'(in_cmd_ff);
               bit_count_in = '0;
               phase_in     = '0;
               if (in_cmd_ff == i2cm_pkg::CMD_WRITE) begin
                  shifter_in = in_byte_ff;
               end
               if (in_cmd_ff == i2cm_pkg::CMD_READ) begin
                  shifter_in = '0;
                  nak_req_in = in_nak_ff;
               end
            end
         end
         OP_START: begin
            case (phase_ff)
               2'd0: begin
                  scl_in    = 1'b0;
                  sda_in    = 1'b1;
                  sda_oe_in = 1'b1;
               end
               2'd1: scl_in = 1'b1;
               2'd2: sda_in = 1'b0;
               default: begin
                  scl_in  = 1'b0;
                  done_in = 1'b1;
               end
            endcase
         end
         OP_STOP: begin
            case (phase_ff)
               2'd0: scl_in = 1'b0;
               2'd1: begin
                  sda_in    = 1'b0;
                  sda_oe_in = 1'b1;
               end
               2'd2: scl_in = 1'b1;
               default: begin
                  sda_in  = 1'b1;
                  done_in = 1'b1;
               end
            endcase
         end
         OP_WRITE: begin
            if (data_bit) begin
               case (phase_ff)
                  2'd0: begin
                     sda_oe_in = 1'b1;
                     sda_in    = shifter_ff[7];
                  end
                  2'd1: scl_in = 1'b1;
                  default: begin
                     scl_in       = 1'b0;
                     shifter_in   = {shifter_ff[6:0], 1'b0};
                     bit_count_in = bit_count_ff + BCW'(1);
                     phase_in     = '0;
                  end
               endcase
            end else begin
               // Acknowledge slot: release SDA and sample the target's answer.
               case (phase_ff)
                  2'd0: begin
                     sda_in    = 1'b1;
                     sda_oe_in = 1'b0;
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     ack_in = in_sample_ff;
                  end
                  default: begin
                     scl_in  = 1'b0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         OP_READ: begin
            if (data_bit) begin
               case (phase_ff)
                  2'd0: begin
                     sda_in    = 1'b1;
                     sda_oe_in = 1'b0;
                  end
                  2'd1: begin
                     scl_in     = 1'b1;
                     shifter_in = {shifter_ff[6:0], in_sample_ff};
                  end
                  default: begin
                     scl_in       = 1'b0;
                     bit_count_in = bit_count_ff + BCW'(1);
                     phase_in     = '0;
                  end
               endcase
            end else begin
               // Answer slot: drive ACK or NAK, then hand over the byte.
               case (phase_ff)
                  2'd0: begin
                     sda_oe_in = 1'b1;
                     sda_in    = nak_req_ff;
                  end
                  2'd1: scl_in = 1'b1;
                  default: begin
                     scl_in         = 1'b0;
                     sda_in         = 1'b1;
                     read_result_in = shifter_ff;
                     done_in        = 1'b1;
                  end
               endcase
            end
         end
         default: done_in = 1'b1;
      endcase

      if (done_in) begin
         op_in        = OP_IDLE;
         bit_count_in = '0;
         phase_in     = '0;
      end
   end

   // Input register: payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_cmd_ff    <= req_cmd;
         in_byte_ff   <= req_write_byte;
         in_nak_ff    <= req_send_nak;
         in_sample_ff <= req_sda_sample;
      end
   end

   // Engine state and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff          <= OP_IDLE;
         bit_count_ff   <= '0;
         phase_ff       <= '0;
         shifter_ff     <= '0;
         nak_req_ff     <= 1'b0;
         ack_ff         <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         sda_oe_ff      <= 1'b1;
         read_result_ff <= '0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            op_ff          <= op_in;
            bit_count_ff   <= bit_count_in;
            phase_ff       <= phase_in;
            shifter_ff     <= shifter_in;
            nak_req_ff     <= nak_req_in;
            ack_ff         <= ack_in;
            scl_ff         <= scl_in;
            sda_ff         <= sda_in;
            sda_oe_ff      <= sda_oe_in;
            read_result_ff <= read_result_in;
            done_ff        <= done_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = sda_oe_ff;
   assign rsp_busy_res  = (op_ff != OP_IDLE);
   assign rsp_done_res  = done_ff;
   assign rsp_read_byte = read_result_ff;
   assign rsp_nack      = ack_ff;

endmodule

/* hw/rtl/i2cm_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_level,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_nack
);

   // A transaction that finishes a command leaves the engine idle.
   `ASSERT_IMPL(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)

   // Released SDA always reads as high.
   `ASSERT_IMPL(a_released_high, clock, reset, rsp_valid && !rsp_sda_drive, rsp_sda_level)

   // With the response slot empty the engine never holds off requests.
   `ASSERT_IMPL(a_no_idle_stall, clock, reset, !rsp_valid, req_ready)

   // A stalled response holds every field.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_scl_level) && $stable(rsp_sda_level) && $stable(rsp_sda_drive)
      && $stable(rsp_busy_res) && $stable(rsp_done_res) && $stable(rsp_read_byte)
      && $stable(rsp_nack))

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
